/* rtl/ilbs_pkg.sv */
// ----------------------------------------------------------------------------
// ilbs_pkg: shared types and constants of the interval lookup block
// Table size, value width, status and phase codes, and the request record
// that travels along the chain of search cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ilbs_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 64;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = 7;
  // Two bound checks, then one halving step per cell
  localparam int NUM_CELLS   = 2 + IDX_W;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  // Request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Phase of a request as it moves down the chain
  localparam logic [2:0] PH_DONE     = 3'd0;
  localparam logic [2:0] PH_LOAD_CHK = 3'd1;
  localparam logic [2:0] PH_LOW      = 3'd2;
  localparam logic [2:0] PH_HIGH     = 3'd3;
  localparam logic [2:0] PH_SEARCH   = 3'd4;

  typedef struct packed {
    logic                       vld;
    logic                       is_load;
    logic [2:0]                 phase;
    logic                       wr_en;
    logic signed [VALUE_W-1:0]  key;
    logic [IDX_W-1:0]           addr;
    logic [IDX_W-1:0]           lo;
    logic [IDX_W-1:0]           hi;
    logic [1:0]                 status;
  } item_t;

  // Sign-extend a 32-bit field, then wrap it to the table value width
  function automatic logic signed [VALUE_W-1:0] to_val(input logic [31:0] f);
    logic [63:0] ext;
    ext = {{32{f[31]}}, f};
    return ext[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/interval_lookup_binary_search.sv */
// ----------------------------------------------------------------------------
// interval_lookup_binary_search: breakpoint table with interval lookup
// Loads strictly increasing breakpoints and answers queries by binary search.
// ----------------------------------------------------------------------------
// A request enters a chain of 2 + log2(table size) search cells (8 cells at
// 64 entries): the first two check the query against the first and last
// breakpoint, each following cell makes one halving step. Every cell owns a
// copy of the table and handles a request as a RAM read, then a compare.
// A new request is taken every cycle while the result side keeps up. A
// stall on the result side freezes the whole chain. Loads travel the same
// chain and update each cell's copy as they pass, so every request sees
// exactly the loads taken before it. The table needs no clearing pass
// after reset.
`default_nettype none

module interval_lookup_binary_search (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Request channel
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic                       in_req_type,
  input  wire logic [5:0]                 in_entry_index,
  input  wire logic signed [31:0]         in_breakpoint_value,
  input  wire logic signed [31:0]         in_query_value,
  // Result channel
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [5:0]                 out_value_index,
  output      logic [1:0]                 out_status,
  // Configuration
  input  wire logic                       cfg_we,
  input  wire logic [ilbs_pkg::CNT_W-1:0] cfg_wdata
);

  logic [ilbs_pkg::CNT_W-1:0] cfg_entry_count_r;
  logic                       adv;
  logic [31:0]                idx32;
  logic [31:0]                cnt32;
  logic [31:0]                n32;
  logic [31:0]                nm1;
  logic [31:0]                lo32;
  ilbs_pkg::item_t            in_item;
  ilbs_pkg::item_t            link [ilbs_pkg::NUM_CELLS+1];
  ilbs_pkg::item_t            out_r;

  // Entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entry_count_r <= '0;
    end else if (cfg_we) begin
      cfg_entry_count_r <= cfg_wdata;
    end
  end

  // Advance the chain unless a result waits
  assign adv      = !out_r.vld || out_ready;
  assign in_ready = adv;

  // Build the request record
  assign idx32 = 32'(in_entry_index);
  assign cnt32 = 32'(cfg_entry_count_r);
  assign n32   = (cnt32 > 32'(ilbs_pkg::MAX_ENTRIES)) ? 32'(ilbs_pkg::MAX_ENTRIES) : cnt32;
  assign nm1   = n32 - 32'd1;

  always_comb begin
    in_item         = '0;
    in_item.vld     = in_valid;
    in_item.is_load = (in_req_type == ilbs_pkg::REQ_LOAD);
    in_item.status  = ilbs_pkg::ST_OK;
    in_item.phase   = ilbs_pkg::PH_DONE;
    if (in_req_type == ilbs_pkg::REQ_LOAD) begin
      in_item.key  = ilbs_pkg::to_val(in_breakpoint_value);
      in_item.addr = idx32[ilbs_pkg::IDX_W-1:0];
      // Drop loads beyond the table; the first entry needs no order check
      if (idx32 < 32'(ilbs_pkg::MAX_ENTRIES)) begin
        if (idx32 == 32'd0) begin
          in_item.wr_en = 1'b1;
        end else begin
          in_item.phase = ilbs_pkg::PH_LOAD_CHK;
        end
      end
    end else begin
      in_item.key = ilbs_pkg::to_val(in_query_value);
      if (n32 < 32'd2) begin
        in_item.status = ilbs_pkg::ST_SHORT;
      end else begin
        in_item.phase = ilbs_pkg::PH_LOW;
        in_item.hi    = nm1[ilbs_pkg::IDX_W-1:0];
      end
    end
  end

  // Chain of search cells
  assign link[0] = in_item;

  for (genvar k = 0; k < ilbs_pkg::NUM_CELLS; k++) begin : g_cell
    ilbs_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .item_i(link[k]),
      .item_o(link[k+1])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else if (adv) begin
      out_r <= link[ilbs_pkg::NUM_CELLS];
    end
  end

  assign lo32            = 32'(out_r.lo);
  assign out_valid       = out_r.vld;
  assign out_value_index = lo32[5:0];
  assign out_status      = out_r.status;

  // Requests are refused only while a result is held
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused without a held result");

  // Error results carry index zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ilbs_pkg::ST_ORDER || out_status == ilbs_pkg::ST_SHORT)
      |-> out_value_index == 6'd0)
    else $error("error result with nonzero index");

  // A query never reports an order error
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_r.is_load |-> out_status != ilbs_pkg::ST_ORDER)
    else $error("order error on a query");

endmodule

`default_nettype wire

/* rtl/ilbs_ram.sv */
// ----------------------------------------------------------------------------
// ilbs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; a read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ilbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/ilbs_cell.sv */
// ----------------------------------------------------------------------------
// ilbs_cell: one step of the breakpoint search chain
// Keeps its own copy of the breakpoint table. Stage A reads the entry the
// request needs, stage B compares and narrows the window (or checks a load)
// and writes accepted loads into the local copy as they pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ilbs_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire ilbs_pkg::item_t item_i,
  output      ilbs_pkg::item_t item_o
);

  ilbs_pkg::item_t a_r;
  ilbs_pkg::item_t b_r;
  ilbs_pkg::item_t upd;

  logic [ilbs_pkg::IDX_W:0]           a_sum;
  logic [ilbs_pkg::IDX_W-1:0]         a_mid;
  logic [ilbs_pkg::IDX_W-1:0]         rd_addr;
  logic [ilbs_pkg::IDX_W:0]           b_sum;
  logic [ilbs_pkg::IDX_W-1:0]         b_mid;
  logic [ilbs_pkg::IDX_W-1:0]         b_span;
  logic                               ram_we;
  logic [ilbs_pkg::VALUE_W-1:0]       ram_q;
  logic                               fwd_hit;
  logic                               fwd_r;
  logic [ilbs_pkg::VALUE_W-1:0]       fwd_data_r;
  logic [ilbs_pkg::VALUE_W-1:0]       entry;
  logic                               gt;

  // Stage A: pick the entry to read
  assign a_sum = {1'b0, a_r.lo} + {1'b0, a_r.hi};
  assign a_mid = a_sum[ilbs_pkg::IDX_W:1];

  always_comb begin
    unique case (a_r.phase)
      ilbs_pkg::PH_LOAD_CHK: rd_addr = a_r.addr - ilbs_pkg::IDX_W'(1);
      ilbs_pkg::PH_LOW:      rd_addr = '0;
      ilbs_pkg::PH_HIGH:     rd_addr = a_r.hi;
      ilbs_pkg::PH_SEARCH:   rd_addr = a_mid;
      default:               rd_addr = '0;
    endcase
  end

  // Local table copy, written by loads leaving stage B
  assign ram_we = adv && upd.vld && upd.is_load && upd.wr_en;

  ilbs_ram #(
    .WIDTH(ilbs_pkg::VALUE_W),
    .DEPTH(ilbs_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(upd.addr),
    .wdata(upd.key),
    .re   (adv),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // Bypass the write that lands in the same cycle as the read
  assign fwd_hit = upd.vld && upd.is_load && upd.wr_en && (upd.addr == rd_addr);

  // Advance both stages together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
      b_r.vld <= 1'b0;
      fwd_r   <= 1'b0;
    end else if (adv) begin
      a_r        <= item_i;
      b_r        <= a_r;
      fwd_r      <= fwd_hit;
      fwd_data_r <= upd.key;
    end
  end

  // Stage B: compare and narrow
  assign entry  = fwd_r ? fwd_data_r : ram_q;
  assign gt     = $signed(b_r.key) > $signed(entry);
  assign b_sum  = {1'b0, b_r.lo} + {1'b0, b_r.hi};
  assign b_mid  = b_sum[ilbs_pkg::IDX_W:1];
  assign b_span = b_r.hi - b_r.lo;

  always_comb begin
    upd = b_r;
    unique case (b_r.phase)
      ilbs_pkg::PH_LOAD_CHK: begin
        if (gt) begin
          upd.wr_en = 1'b1;
        end else begin
          upd.status = ilbs_pkg::ST_ORDER;
        end
        upd.phase = ilbs_pkg::PH_DONE;
      end
      ilbs_pkg::PH_LOW: begin
        // At or below the first breakpoint: index zero
        upd.phase = gt ? ilbs_pkg::PH_HIGH : ilbs_pkg::PH_DONE;
      end
      ilbs_pkg::PH_HIGH: begin
        // Above the last breakpoint: last index
        if (gt) begin
          upd.lo    = b_r.hi;
          upd.phase = ilbs_pkg::PH_DONE;
        end else begin
          upd.phase = ilbs_pkg::PH_SEARCH;
        end
      end
      ilbs_pkg::PH_SEARCH: begin
        if (b_span > ilbs_pkg::IDX_W'(1)) begin
          if (gt) begin
            upd.lo = b_mid;
          end else begin
            upd.hi = b_mid;
          end
        end else begin
          upd.phase = ilbs_pkg::PH_DONE;
        end
      end
      default: begin
        upd = b_r;
      end
    endcase
  end

  assign item_o = upd;

  // Search window never collapses or inverts
  assert property (@(posedge clk) disable iff (!rst_n)
    b_r.vld && !b_r.is_load && b_r.phase == ilbs_pkg::PH_SEARCH |-> b_r.lo < b_r.hi)
    else $error("search window inverted");

  // A stalled chain holds its requests
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(b_r) && $stable(a_r))
    else $error("cell moved during stall");

endmodule

`default_nettype wire
